>>> sv/cartridge_bank_mapper_assert.svh
// Assertion macros used by the cartridge bank mapper checker.
`ifndef CARTRIDGE_BANK_MAPPER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cartridge_bank_mapper: assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cartridge_bank_mapper: assertion failed");

`endif

>>> sv/cbm_pkg.sv
// Types, constants and a helper function of the cartridge bank mapper.
package cbm_pkg;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_MBC1  = 3'd1,
        KIND_MBC2  = 3'd2,
        KIND_MBC3  = 3'd3,
        KIND_OTHER = 3'd4
    } kind_t;

    localparam logic [2:0] TGT_IGNORED  = 3'd0;
    localparam logic [2:0] TGT_INTERNAL = 3'd1;
    localparam logic [2:0] TGT_ROM      = 3'd2;
    localparam logic [2:0] TGT_RAM      = 3'd3;
    localparam logic [2:0] TGT_JOYPAD   = 3'd4;
    localparam logic [2:0] TGT_RTC      = 3'd5;

    localparam logic        OP_READ  = 1'b0;
    localparam logic        OP_WRITE = 1'b1;

    // Register index of the cartridge header type, taken from paddr[2].
    localparam logic        REG_CART_HEADER = 1'b0;

    localparam logic [15:0] ADDR_JOYPAD = 16'hff00;
    localparam logic [15:0] ADDR_DMA    = 16'hff46;

    localparam int MAPPED_W = 22;

    typedef struct packed {
        logic              operation;
        logic [15:0]       address;
        logic [7:0]        write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]          target;
        logic [MAPPED_W-1:0] mapped_address;
        logic                dma_start;
    } result_t;

    typedef struct packed {
        logic [6:0] mbc1_rom_bank;
        logic [1:0] mbc1_ram_bank;
        logic       mbc1_ram_enable;
        logic       mbc1_bank_mode;
        logic [4:0] mbc2_rom_bank;
        logic       mbc2_ram_enable;
        logic [7:0] mbc3_rom_bank;
        logic [7:0] mbc3_ram_bank;
        logic       mbc3_ram_enable;
    } bank_state_t;

    localparam bank_state_t BANK_STATE_RESET = '{
        mbc1_rom_bank:   7'd1,
        mbc1_ram_bank:   2'd0,
        mbc1_ram_enable: 1'b0,
        mbc1_bank_mode:  1'b0,
        mbc2_rom_bank:   5'd1,
        mbc2_ram_enable: 1'b0,
        mbc3_rom_bank:   8'd1,
        mbc3_ram_bank:   8'd0,
        mbc3_ram_enable: 1'b0
    };

    function automatic kind_t kind_of(logic [7:0] t);
        kind_t k;
        if (t == 8'h00) begin
            k = KIND_NONE;
        end else if (t inside {[8'h01:8'h03]}) begin
            k = KIND_MBC1;
        end else if (t inside {8'h05, 8'h06}) begin
            k = KIND_MBC2;
        end else if (t inside {[8'h0f:8'h13]}) begin
            k = KIND_MBC3;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

>>> sv/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: handshake stages, configuration port and submodules.
// The mapper takes one bus access per cycle unless m_ready holds the result register, and
// returns its target and physical address through an input register and a result
// register; s_ready stays high while the result register can move on. Bank register
// writes take effect for the very next access. The controller kind follows the cartridge
// header type byte written at byte address 0 of the configuration port; write it only
// while no access is in flight. There is no clearing pass after reset.
module cartridge_bank_mapper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_target,
    output logic [21:0] m_mapped_address,
    output logic        m_dma_start
);

    logic [7:0]           cart_header_type_reg;
    logic                 in_valid_reg;
    cbm_pkg::req_t        in_req_reg;
    logic                 out_valid_reg;
    cbm_pkg::result_t     out_res_reg;
    logic                 advance;
    logic                 cfg_write;
    cbm_pkg::kind_t       kind;
    cbm_pkg::bank_state_t state;
    cbm_pkg::bank_state_t state_next;
    cbm_pkg::result_t     res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == cbm_pkg::REG_CART_HEADER);
    assign prdata    = (paddr[2] == cbm_pkg::REG_CART_HEADER) ?
                       {24'd0, cart_header_type_reg} : 32'd0;
    assign kind      = cbm_pkg::kind_of(cart_header_type_reg);

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cart_header_type_reg <= 8'd0;
        end else if (cfg_write) begin
            cart_header_type_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= '{operation: s_operation, address: s_address,
                            write_data: s_write_data};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    cbm_access_decode u_decode (
        .req        (in_req_reg),
        .kind       (kind),
        .state      (state),
        .res        (res),
        .state_next (state_next)
    );

    cbm_bank_regs u_bank_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .state_next (state_next),
        .state      (state)
    );

    assign m_valid          = out_valid_reg;
    assign m_target         = out_res_reg.target;
    assign m_mapped_address = out_res_reg.mapped_address;
    assign m_dma_start      = out_res_reg.dma_start;

endmodule

>>> sv/cbm_bank_regs.sv
// Bank, enable and mode registers of the supported cartridge controllers.
module cbm_bank_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 update,
    input  cbm_pkg::bank_state_t state_next,
    output cbm_pkg::bank_state_t state
);

    cbm_pkg::bank_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbm_pkg::BANK_STATE_RESET;
        end else if (update) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> sv/cbm_access_decode.sv
// Combinational decode of one bus access into its target, address and register updates.
module cbm_access_decode (
    input  cbm_pkg::req_t        req,
    input  cbm_pkg::kind_t       kind,
    input  cbm_pkg::bank_state_t state,
    output cbm_pkg::result_t     res,
    output cbm_pkg::bank_state_t state_next
);

    logic [15:0] a;
    logic [7:0]  d;
    logic        in_rom_bank;
    logic        in_ram_window;
    logic        win_hit;
    logic        win_rtc;
    logic [cbm_pkg::MAPPED_W-1:0] win_addr;

    assign a             = req.address;
    assign d             = req.write_data;
    assign in_rom_bank   = (a[15:14] == 2'b01);
    assign in_ram_window = (a[15:13] == 3'b101);
    assign win_hit       = state.mbc3_ram_enable && (state.mbc3_ram_bank != 8'd0)
                           && in_ram_window;
    assign win_rtc       = |state.mbc3_ram_bank[7:3];
    assign win_addr      = {6'd0, state.mbc3_ram_bank[2:0], a[12:0]};

    always_comb begin
        res.target         = cbm_pkg::TGT_INTERNAL;
        res.mapped_address = {6'd0, a};
        res.dma_start      = 1'b0;
        state_next         = state;

        if (req.operation == cbm_pkg::OP_READ) begin
            if (kind == cbm_pkg::KIND_MBC1 && state.mbc1_rom_bank != 7'd0 && in_rom_bank) begin
                res.target         = cbm_pkg::TGT_ROM;
                res.mapped_address = {1'b0, state.mbc1_rom_bank, a[13:0]};
            end else if (kind == cbm_pkg::KIND_MBC2 && state.mbc2_rom_bank != 5'd0
                         && in_rom_bank) begin
                res.target         = cbm_pkg::TGT_ROM;
                res.mapped_address = {3'd0, state.mbc2_rom_bank, a[13:0]};
            end else if (kind == cbm_pkg::KIND_MBC3 && state.mbc3_rom_bank != 8'd0
                         && in_rom_bank) begin
                res.target         = cbm_pkg::TGT_ROM;
                res.mapped_address = {state.mbc3_rom_bank, a[13:0]};
            end else if (kind == cbm_pkg::KIND_MBC3 && win_hit) begin
                res.target         = win_rtc ? cbm_pkg::TGT_RTC : cbm_pkg::TGT_RAM;
                res.mapped_address = win_rtc ? '0 : win_addr;
            end
        end else if (a == cbm_pkg::ADDR_JOYPAD) begin
            res.target = cbm_pkg::TGT_JOYPAD;
        end else if (a == cbm_pkg::ADDR_DMA) begin
            res.dma_start = 1'b1;
        end else if (a[15]) begin
            if (kind == cbm_pkg::KIND_OTHER) begin
                res.target         = cbm_pkg::TGT_IGNORED;
                res.mapped_address = '0;
            end else if (kind == cbm_pkg::KIND_MBC3 && win_hit) begin
                res.target         = win_rtc ? cbm_pkg::TGT_RTC : cbm_pkg::TGT_RAM;
                res.mapped_address = win_rtc ? '0 : win_addr;
            end
        end else begin
            res.target         = cbm_pkg::TGT_IGNORED;
            res.mapped_address = '0;
            case (kind)
                cbm_pkg::KIND_MBC1: begin
                    case (a[14:13])
                        2'b00: state_next.mbc1_ram_enable = (d != 8'd0);
                        2'b01: state_next.mbc1_rom_bank =
                            (d[4:0] == 5'd0) ? 7'd1 : {2'd0, d[4:0]};
                        2'b10: begin
                            if (!state.mbc1_bank_mode) begin
                                state_next.mbc1_rom_bank =
                                    state.mbc1_rom_bank | {d[1:0], 5'd0};
                            end else begin
                                state_next.mbc1_ram_bank = d[1:0];
                            end
                        end
                        default: state_next.mbc1_bank_mode = (d != 8'd0);
                    endcase
                end
                cbm_pkg::KIND_MBC2: begin
                    if (a[14]) begin
                        res.target         = cbm_pkg::TGT_INTERNAL;
                        res.mapped_address = {6'd0, a};
                    end else if (a[13]) begin
                        state_next.mbc2_rom_bank = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
                    end else begin
                        state_next.mbc2_ram_enable = (d != 8'd0);
                    end
                end
                cbm_pkg::KIND_MBC3: begin
                    case (a[14:13])
                        2'b00: state_next.mbc3_ram_enable = (d != 8'd0);
                        2'b01: state_next.mbc3_rom_bank = (d == 8'd0) ? 8'd1 : d;
                        2'b10: state_next.mbc3_ram_bank = d;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

>>> sv/cbm_checker.sv
// Port-level checker of the cartridge bank mapper and its bind statement.
`include "cartridge_bank_mapper_assert.svh"

module cbm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_target,
    input logic [21:0] m_mapped_address,
    input logic        m_dma_start
);

    logic [25:0] out_word;
    logic        out_stall;
    logic        dma_ok;
    logic        joypad_ok;
    logic        zero_target;

    assign out_word    = {m_target, m_mapped_address, m_dma_start};
    assign out_stall   = m_valid && !m_ready;
    assign dma_ok      = (m_target == cbm_pkg::TGT_INTERNAL)
                         && (m_mapped_address == {6'd0, cbm_pkg::ADDR_DMA});
    assign joypad_ok   = (m_mapped_address == {6'd0, cbm_pkg::ADDR_JOYPAD}) && !m_dma_start;
    assign zero_target = (m_target == cbm_pkg::TGT_IGNORED) || (m_target == cbm_pkg::TGT_RTC);

    `CBM_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(out_word))
    `CBM_ASSERT_NOW(a_dma_word, m_valid && m_dma_start, dma_ok)
    `CBM_ASSERT_NOW(a_joypad_addr, m_valid && m_target == cbm_pkg::TGT_JOYPAD, joypad_ok)
    `CBM_ASSERT_NOW(a_zero_addr, m_valid && zero_target, m_mapped_address == 22'd0)
    `CBM_ASSERT_NOW(a_target_range, m_valid, m_target <= cbm_pkg::TGT_RTC)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_target         (m_target),
    .m_mapped_address (m_mapped_address),
    .m_dma_start      (m_dma_start)
);
